@@ src/glu_pkg.sv @@
// ----------------------------------------------------------------------------
// glu_pkg: shared types and constants for the GCD / LCM unit
// Field widths, micro-op and jump-condition codes, the control word layout
// and the microcode program itself.
// ----------------------------------------------------------------------------
package glu_pkg;

  // Channel field widths
  localparam int unsigned OP_W    = 1;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned RES_W   = 64;

  // Step counter width and program addresses
  localparam int unsigned PC_W = 3;

  localparam logic [PC_W-1:0] ADDR_IDLE = 3'd0;
  localparam logic [PC_W-1:0] ADDR_GCD  = 3'd1;
  localparam logic [PC_W-1:0] ADDR_GFIN = 3'd2;
  localparam logic [PC_W-1:0] ADDR_DIV  = 3'd3;
  localparam logic [PC_W-1:0] ADDR_MUL  = 3'd4;
  localparam logic [PC_W-1:0] ADDR_OUT  = 3'd7;

  // Selector code on the input channel
  localparam logic OP_GCD = 1'b0;

  // Datapath micro-operations
  typedef enum logic [2:0] {
    UOP_NOP  = 3'd0,
    UOP_LOAD = 3'd1,
    UOP_GCD  = 3'd2,
    UOP_GFIN = 3'd3,
    UOP_DIV  = 3'd4,
    UOP_MUL  = 3'd5,
    UOP_OUT  = 3'd6
  } uop_e;

  // Jump conditions: jump to target when true, else fall to the next step
  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_NO_IN    = 3'd1,
    COND_GCD_BUSY = 3'd2,
    COND_NO_LCM   = 3'd3,
    COND_DIV_MORE = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_e;

  typedef struct packed {
    uop_e            uop;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    uop_e uop;
    logic load;
  } glu_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic gcd_busy;
    logic no_lcm;
    logic div_more;
  } glu_stat_t;

  // Microcode ROM. The output step sits at the top address so that its
  // fall-through wraps back to idle.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      ADDR_IDLE: w = '{UOP_LOAD, COND_NO_IN,    ADDR_IDLE};
      ADDR_GCD:  w = '{UOP_GCD,  COND_GCD_BUSY, ADDR_GCD};
      ADDR_GFIN: w = '{UOP_GFIN, COND_NO_LCM,   ADDR_OUT};
      ADDR_DIV:  w = '{UOP_DIV,  COND_DIV_MORE, ADDR_DIV};
      ADDR_MUL:  w = '{UOP_MUL,  COND_ALWAYS,   ADDR_OUT};
      ADDR_OUT:  w = '{UOP_OUT,  COND_OUT_BUSY, ADDR_OUT};
      default:   w = '{UOP_NOP,  COND_ALWAYS,   ADDR_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ src/glu_if.sv @@
// ----------------------------------------------------------------------------
// glu_if: valid/ready channels of the GCD / LCM unit
// Operand channel and result channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
interface glu_in_if
  import glu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] first_operand;
  logic [FIELD_W-1:0] second_operand;

  modport source (output valid, output op, output first_operand,
                  output second_operand, input ready);
  modport sink   (input valid, input op, input first_operand,
                  input second_operand, output ready);
endinterface

interface glu_out_if
  import glu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

@@ src/glu_datapath.sv @@
// ----------------------------------------------------------------------------
// glu_datapath: operand registers, binary GCD reducer, divider, multiplier
// Each micro-op from the sequencer updates the working registers for one
// step; flags go back for the conditional jumps.
// ----------------------------------------------------------------------------
module glu_datapath
  import glu_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic               clk_i,
  input  glu_ctrl_t          ctrl_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [FIELD_W-1:0] first_operand_i,
  input  logic [FIELD_W-1:0] second_operand_i,
  output glu_stat_t          stat_o,
  output logic [RES_W-1:0]   res_o
);

  localparam int unsigned K_W = $clog2(W);

  logic             op_q,   op_d;
  logic [W-1:0]     a_q,    a_d;
  logic [W-1:0]     b_q,    b_d;
  logic [W-1:0]     x_q,    x_d;
  logic [W-1:0]     y_q,    y_d;
  logic [K_W-1:0]   k_q,    k_d;
  logic [W-1:0]     g_q,    g_d;
  logic [W-1:0]     rem_q,  rem_d;
  logic [W-1:0]     quot_q, quot_d;
  logic [K_W-1:0]   cnt_q,  cnt_d;
  logic [RES_W-1:0] res_q,  res_d;

  logic             gcd_busy;
  logic [W-1:0]     g_full;
  logic [W:0]       rem_sh;
  logic [2*W-1:0]   prod;

  assign gcd_busy = (x_q != '0) && (y_q != '0);
  // one of x, y is zero when the reducer stops
  assign g_full   = (x_q | y_q) << k_q;
  assign rem_sh   = {rem_q, quot_q[W-1]};
  assign prod     = (2*W)'(quot_q) * (2*W)'(b_q);

  assign stat_o.gcd_busy = gcd_busy;
  assign stat_o.no_lcm   = (op_q == OP_GCD) || (a_q == '0) || (b_q == '0);
  assign stat_o.div_more = (cnt_q != '0);
  assign res_o           = res_q;

  // Next-state logic per micro-op
  always_comb begin
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    g_d    = g_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    case (ctrl_i.uop)
      UOP_LOAD: begin
        if (ctrl_i.load) begin
          op_d = op_i[0];
          a_d  = first_operand_i[W-1:0];
          b_d  = second_operand_i[W-1:0];
          x_d  = first_operand_i[W-1:0];
          y_d  = second_operand_i[W-1:0];
          k_d  = '0;
        end
      end
      // binary GCD: strip a common factor of two, halve an even side,
      // or halve the difference of two odd values
      UOP_GCD: begin
        if (gcd_busy) begin
          if (!x_q[0] && !y_q[0]) begin
            x_d = x_q >> 1;
            y_d = y_q >> 1;
            k_d = k_q + K_W'(1);
          end else if (!x_q[0]) begin
            x_d = x_q >> 1;
          end else if (!y_q[0]) begin
            y_d = y_q >> 1;
          end else if (x_q >= y_q) begin
            x_d = (x_q - y_q) >> 1;
          end else begin
            y_d = (y_q - x_q) >> 1;
          end
        end
      end
      // restore the common power of two, set up the divide a / g
      UOP_GFIN: begin
        g_d    = g_full;
        rem_d  = '0;
        quot_d = a_q;
        cnt_d  = K_W'(W - 1);
        res_d  = (op_q == OP_GCD) ? RES_W'(g_full) : '0;
      end
      // restoring divide, one quotient bit per step
      UOP_DIV: begin
        if (rem_sh >= {1'b0, g_q}) begin
          rem_d  = W'(rem_sh - {1'b0, g_q});
          quot_d = {quot_q[W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[W-1:0];
          quot_d = {quot_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - K_W'(1);
      end
      UOP_MUL: begin
        res_d = RES_W'(prod);
      end
      default: begin
      end
    endcase
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    y_q    <= y_d;
    k_q    <= k_d;
    g_q    <= g_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

endmodule

@@ src/gcd_lcm_unit_core.sv @@
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core: microcoded GCD / LCM unit
// Path from operand beat to result in the output register: GCD runs the
// binary reduction loop, and LCM adds W divide steps and one multiply after
// it; W = OPERAND_WIDTH.
// One item at a time: the next operand beat is taken once the result has
// moved to the output register, which holds it until the sink takes it.
// Reset clears the step counter and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core
  import glu_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  glu_in_if.sink    in_i,
  glu_out_if.source out_o
);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] out_data_q;

  ucode_t           uword;
  glu_ctrl_t        ctrl;
  glu_stat_t        stat;
  logic [RES_W-1:0] dp_res;
  logic             in_fire;
  logic             out_busy;
  logic             out_load;
  logic             jump;

  assign uword    = ucode_rom(pc_q);
  assign in_i.ready = (pc_q == ADDR_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_busy = out_valid_q && !out_o.ready;
  assign out_load = (uword.uop == UOP_OUT) && !out_busy;

  assign ctrl.uop  = uword.uop;
  assign ctrl.load = in_fire;

  // Datapath
  glu_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .ctrl_i           (ctrl),
    .op_i             (in_i.op),
    .first_operand_i  (in_i.first_operand),
    .second_operand_i (in_i.second_operand),
    .stat_o           (stat),
    .res_o            (dp_res)
  );

  // Jump condition select
  always_comb begin
    case (uword.cond)
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !in_fire;
      COND_GCD_BUSY: jump = stat.gcd_busy;
      COND_NO_LCM:   jump = stat.no_lcm;
      COND_DIV_MORE: jump = stat.div_more;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // Step counter: jump or fall through (top step wraps to idle)
  assign pc_d = jump ? uword.target : pc_q + PC_W'(1);

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ADDR_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= dp_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_data_q;

`ifndef SYNTHESIS
  // an accepted operand beat always starts the reduction loop
  a_accept_to_gcd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pc_q == ADDR_GCD)
    else $error("operand beat did not start GCD loop");

  // result handover fills the output register and frees the input side
  a_out_handover : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && pc_q == ADDR_IDLE)
    else $error("result handover lost");

  // the sequencer never lands on an unprogrammed step
  a_pc_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == ADDR_IDLE || pc_q == ADDR_GCD || pc_q == ADDR_GFIN ||
    pc_q == ADDR_DIV || pc_q == ADDR_MUL || pc_q == ADDR_OUT)
    else $error("step counter on unused address");

  // a waiting result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |-> !out_load)
    else $error("output register overwritten while stalled");
`endif

endmodule
